// ----- sv/fihcv_pkg.sv -----
// Package: constants, types and the CRC step for the image header check.
`timescale 1ns / 1ps
package fihcv_pkg;

  localparam int HEADER_BYTES = 19;
  localparam int HDR_IDX_W    = 5;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST     = HDR_IDX_W'(HEADER_BYTES - 1);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_TYPE = HDR_IDX_W'(2);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_LEN0 = HDR_IDX_W'(3);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_LEN3 = HDR_IDX_W'(6);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    EMIT_NONE  = 2'd0,
    EMIT_TYPE  = 2'd1,
    EMIT_FINAL = 2'd2
  } emit_t;

  typedef enum logic [1:0] {
    REASON_OK   = 2'd0,
    REASON_TYPE = 2'd1,
    REASON_CRC  = 2'd2
  } reason_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        crc_en;
    logic        crc_first;
    emit_t       emit;
    logic [15:0] stored_crc;
    logic [31:0] length;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [7:0] x;
    x = c[15:8] ^ b;
    x = x ^ {4'h0, x[7:4]};
    return {c[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

// ----- sv/fihcv_if.sv -----
// Interfaces: image byte channel and verdict channel.
`timescale 1ns / 1ps
interface fihcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       start_of_image;
  modport source (output valid, output image_byte, output start_of_image, input ready);
  modport sink   (input valid, input image_byte, input start_of_image, output ready);
endinterface

interface fihcv_out_if;
  logic        valid;
  logic        ready;
  logic        image_valid;
  logic [1:0]  fail_reason;
  logic [31:0] payload_length;
  logic [15:0] computed_crc;
  modport source (output valid, output image_valid, output fail_reason,
                  output payload_length, output computed_crc, input ready);
  modport sink   (input valid, input image_valid, input fail_reason,
                  input payload_length, input computed_crc, output ready);
endinterface

// ----- sv/fihcv_front.sv -----
// Front end: tracks header position and payload count, issues CRC commands.
`timescale 1ns / 1ps
module fihcv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              word_valid,
  output logic              word_ready,
  input  logic [7:0]        image_byte,
  input  logic              start_of_image,
  input  logic              queue_full,
  output logic              push,
  output fihcv_pkg::cmd_t   push_cmd
);

  logic [7:0]                      expected_type;
  logic [fihcv_pkg::HDR_IDX_W-1:0] header_index, header_index_next;
  logic [15:0]                     stored_crc, stored_crc_next;
  logic [31:0]                     length_field, length_field_next;
  logic [31:0]                     bytes_remaining, bytes_remaining_next;
  logic                            in_payload, in_payload_next;
  logic                            verdict_done, verdict_done_next;
  logic                            accept;
  logic                            cmd_push;

  assign word_ready = !queue_full;
  assign accept     = word_valid && word_ready;
  assign push       = accept && cmd_push;

  always_comb begin
    header_index_next    = header_index;
    stored_crc_next      = stored_crc;
    length_field_next    = length_field;
    bytes_remaining_next = bytes_remaining;
    in_payload_next      = in_payload;
    verdict_done_next    = verdict_done;
    cmd_push             = 1'b0;
    push_cmd.data        = image_byte;
    push_cmd.crc_en      = 1'b0;
    push_cmd.crc_first   = 1'b0;
    push_cmd.emit        = fihcv_pkg::EMIT_NONE;
    push_cmd.stored_crc  = 16'h0000;
    push_cmd.length      = 32'h0000_0000;
    if (start_of_image) begin
      header_index_next    = '0;
      stored_crc_next      = 16'h0000;
      length_field_next    = 32'h0000_0000;
      bytes_remaining_next = 32'h0000_0000;
      in_payload_next      = 1'b0;
      verdict_done_next    = 1'b0;
    end
    if (!verdict_done_next) begin
      if (in_payload_next) begin
        cmd_push             = 1'b1;
        push_cmd.crc_en      = 1'b1;
        bytes_remaining_next = bytes_remaining_next - 32'd1;
        if (bytes_remaining_next == 32'h0000_0000) begin
          push_cmd.emit       = fihcv_pkg::EMIT_FINAL;
          push_cmd.stored_crc = stored_crc_next;
          push_cmd.length     = length_field_next;
          verdict_done_next   = 1'b1;
          in_payload_next     = 1'b0;
        end
      end else if (header_index_next < fihcv_pkg::HDR_IDX_TYPE) begin
        stored_crc_next = {stored_crc_next[7:0], image_byte};
        if (header_index_next >= fihcv_pkg::HDR_LAST) begin
          cmd_push = 1'b1;
          if (length_field_next == 32'h0000_0000) begin
            push_cmd.emit       = fihcv_pkg::EMIT_FINAL;
            push_cmd.stored_crc = stored_crc_next;
            push_cmd.length     = length_field_next;
            verdict_done_next   = 1'b1;
          end else begin
            bytes_remaining_next = length_field_next;
            in_payload_next      = 1'b1;
          end
        end else begin
          header_index_next = header_index_next + 1'b1;
        end
      end else if (header_index_next == fihcv_pkg::HDR_IDX_TYPE &&
                   image_byte != expected_type) begin
        cmd_push          = 1'b1;
        push_cmd.emit     = fihcv_pkg::EMIT_TYPE;
        verdict_done_next = 1'b1;
        in_payload_next   = 1'b0;
      end else begin
        if (header_index_next >= fihcv_pkg::HDR_IDX_LEN0 &&
            header_index_next <= fihcv_pkg::HDR_IDX_LEN3) begin
          length_field_next = {length_field_next[23:0], image_byte};
        end
        cmd_push           = 1'b1;
        push_cmd.crc_en    = 1'b1;
        push_cmd.crc_first = (header_index_next == fihcv_pkg::HDR_IDX_TYPE);
        if (header_index_next >= fihcv_pkg::HDR_LAST) begin
          if (length_field_next == 32'h0000_0000) begin
            push_cmd.emit       = fihcv_pkg::EMIT_FINAL;
            push_cmd.stored_crc = stored_crc_next;
            push_cmd.length     = length_field_next;
            verdict_done_next   = 1'b1;
          end else begin
            bytes_remaining_next = length_field_next;
            in_payload_next      = 1'b1;
          end
        end else begin
          header_index_next = header_index_next + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type   <= 8'h00;
      header_index    <= '0;
      stored_crc      <= 16'h0000;
      length_field    <= 32'h0000_0000;
      bytes_remaining <= 32'h0000_0000;
      in_payload      <= 1'b0;
      verdict_done    <= 1'b1;
    end else begin
      if (cfg_we) begin
        expected_type <= cfg_data;
      end
      if (accept) begin
        header_index    <= header_index_next;
        stored_crc      <= stored_crc_next;
        length_field    <= length_field_next;
        bytes_remaining <= bytes_remaining_next;
        in_payload      <= in_payload_next;
        verdict_done    <= verdict_done_next;
      end
    end
  end

endmodule

// ----- sv/fihcv_queue.sv -----
// Command queue between front end and CRC back end.
`timescale 1ns / 1ps
module fihcv_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fihcv_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output fihcv_pkg::cmd_t pop_cmd,
  output logic            empty
);

  fihcv_pkg::cmd_t                 entries [fihcv_pkg::QUEUE_DEPTH];
  logic [fihcv_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [fihcv_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [fihcv_pkg::QUEUE_PTR_W:0]   count;

  assign full    = (count == (fihcv_pkg::QUEUE_PTR_W+1)'(fihcv_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/fihcv_back.sv -----
// Back end: runs the CRC over queued bytes and registers the verdict.
`timescale 1ns / 1ps
module fihcv_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             queue_empty,
  input  fihcv_pkg::cmd_t  cmd,
  output logic             pop,
  fihcv_out_if.source      verdict_out
);

  logic [15:0] crc_value;
  logic [15:0] crc_base;
  logic [15:0] crc_new;
  logic        out_free;

  assign out_free = !verdict_out.valid || verdict_out.ready;
  assign pop      = !queue_empty && out_free;
  assign crc_base = cmd.crc_first ? fihcv_pkg::CRC_INIT : crc_value;
  assign crc_new  = cmd.crc_en ? fihcv_pkg::crc_byte(crc_base, cmd.data) : crc_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value         <= fihcv_pkg::CRC_INIT;
      verdict_out.valid <= 1'b0;
    end else begin
      if (pop && cmd.emit != fihcv_pkg::EMIT_NONE) begin
        verdict_out.valid <= 1'b1;
      end else if (verdict_out.ready) begin
        verdict_out.valid <= 1'b0;
      end
      if (pop) begin
        crc_value <= crc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (cmd.emit)
        fihcv_pkg::EMIT_TYPE: begin
          verdict_out.image_valid    <= 1'b0;
          verdict_out.fail_reason    <= fihcv_pkg::REASON_TYPE;
          verdict_out.payload_length <= 32'h0000_0000;
          verdict_out.computed_crc   <= 16'h0000;
        end
        fihcv_pkg::EMIT_FINAL: begin
          verdict_out.image_valid    <= (crc_new == cmd.stored_crc);
          verdict_out.fail_reason    <= (crc_new == cmd.stored_crc) ?
                                        fihcv_pkg::REASON_OK : fihcv_pkg::REASON_CRC;
          verdict_out.payload_length <= cmd.length;
          verdict_out.computed_crc   <= crc_new;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/firmware_image_header_crc_verify_unit.sv -----
// Top level: firmware image header check with CRC-16/CCITT-FALSE.
//
//   channel      dir  handshake       payload
//   image_in     in   valid/ready     image_byte[7:0], start_of_image
//   verdict_out  out  valid/ready     image_valid, fail_reason[1:0],
//                                     payload_length[31:0], computed_crc[15:0]
//   cfg          in   cfg_we          cfg_data[7:0] (expected image type)
//
// One byte per cycle; the CRC byte step in the back end sets the rate.
// The byte that ends the check writes its command into the queue; the back end registers the verdict when it pops it.
// rst clears all control state; the block then ignores bytes until a start.
// While a verdict waits, the back holds and a two-entry command queue takes up to
// two more bytes before the input stalls.
`timescale 1ns / 1ps
module firmware_image_header_crc_verify_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  fihcv_in_if.sink    image_in,
  fihcv_out_if.source verdict_out
);

  fihcv_pkg::cmd_t push_cmd;
  fihcv_pkg::cmd_t pop_cmd;
  logic            push;
  logic            pop;
  logic            queue_full;
  logic            queue_empty;

  fihcv_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .word_valid     (image_in.valid),
    .word_ready     (image_in.ready),
    .image_byte     (image_in.image_byte),
    .start_of_image (image_in.start_of_image),
    .queue_full     (queue_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  fihcv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (queue_empty)
  );

  fihcv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .cmd         (pop_cmd),
    .pop         (pop),
    .verdict_out (verdict_out)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the firmware image header CRC check: random images, predicted verdicts.
`timescale 1ns / 1ps
module tb_top;
  import fihcv_pkg::*;

  typedef struct {
    bit          image_valid;
    reason_t     fail_reason;
    bit [31:0]   payload_length;
    bit [15:0]   computed_crc;
  } verdict_t;

  typedef enum {
    IMG_GOOD,
    IMG_BAD_CRC,
    IMG_BAD_TYPE,
    IMG_CUT,
    IMG_TRAIL,
    IMG_HUGE,
    IMG_NOISE
  } image_kind_e;

  class image_verdict_tracker;
    bit [7:0]             expected_type;
    verdict_t             pending[$];
    int                   mismatches;
    int                   bytes_checked;
    int                   verdicts_due;
    bit [HDR_IDX_W-1:0]   hdr_pos;
    bit [15:0]            run_crc;
    bit [15:0]            stored;
    bit [31:0]            len_acc;
    bit [31:0]            remain;
    bit                   payload_phase;
    bit                   done;

    function new();
      expected_type = 8'h00;
      hdr_pos       = '0;
      run_crc       = CRC_INIT;
      stored        = 16'h0000;
      len_acc       = 32'h0;
      remain        = 32'h0;
      payload_phase = 1'b0;
      done          = 1'b1;
    endfunction

    static function bit [15:0] crc_step(bit [15:0] c, bit [7:0] b);
      c = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endfunction

    function void post(bit ok, reason_t why, bit [31:0] len, bit [15:0] crc);
      verdict_t v;
      v.image_valid    = ok;
      v.fail_reason    = why;
      v.payload_length = len;
      v.computed_crc   = crc;
      pending.push_back(v);
      verdicts_due++;
      done          = 1'b1;
      payload_phase = 1'b0;
    endfunction

    function void close_check();
      if (run_crc == stored) begin
        post(1'b1, REASON_OK, len_acc, run_crc);
      end else begin
        post(1'b0, REASON_CRC, len_acc, run_crc);
      end
    endfunction

    function void take_byte(bit [7:0] b, bit s);
      if (s) begin
        hdr_pos       = '0;
        run_crc       = CRC_INIT;
        stored        = 16'h0000;
        len_acc       = 32'h0;
        remain        = 32'h0;
        payload_phase = 1'b0;
        done          = 1'b0;
      end
      if (done) return;
      bytes_checked++;
      if (payload_phase) begin
        run_crc = crc_step(run_crc, b);
        remain  = remain - 1;
        if (remain == 0) close_check();
        return;
      end
      if (hdr_pos < HDR_IDX_TYPE) begin
        stored = {stored[7:0], b};
      end else begin
        if (hdr_pos == HDR_IDX_TYPE && b != expected_type) begin
          post(1'b0, REASON_TYPE, 32'h0, 16'h0000);
          return;
        end
        if (hdr_pos >= HDR_IDX_LEN0 && hdr_pos <= HDR_IDX_LEN3) len_acc = {len_acc[23:0], b};
        run_crc = crc_step(run_crc, b);
      end
      if (hdr_pos >= HDR_LAST) begin
        if (len_acc == 0) begin
          close_check();
        end else begin
          remain        = len_acc;
          payload_phase = 1'b1;
        end
        return;
      end
      hdr_pos = hdr_pos + 1'b1;
    endfunction

    function void check_verdict(logic iv, logic [1:0] fr, logic [31:0] pl, logic [15:0] cc);
      verdict_t want;
      if (pending.size() == 0) begin
        report("verdict arrived with none pending");
        return;
      end
      want = pending.pop_front();
      if (iv !== want.image_valid)
        report($sformatf("image_valid got %b want %b", iv, want.image_valid));
      if (fr !== want.fail_reason)
        report($sformatf("fail_reason got %0d want %0d", fr, want.fail_reason));
      if (pl !== want.payload_length)
        report($sformatf("payload_length got %h want %h", pl, want.payload_length));
      if (cc !== want.computed_crc)
        report($sformatf("computed_crc got %h want %h", cc, want.computed_crc));
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_data;
  bit         quiet;

  fihcv_in_if  image_ch ();
  fihcv_out_if verdict_ch ();

  image_verdict_tracker tracker = new();

  firmware_image_header_crc_verify_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .image_in    (image_ch),
    .verdict_out (verdict_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    verdict_ch.ready <= rst ? 1'b0 : (quiet || $urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      tracker.check_verdict(verdict_ch.image_valid, verdict_ch.fail_reason,
                            verdict_ch.payload_length, verdict_ch.computed_crc);
    end
  end

  task automatic send_byte(input bit [7:0] b, input bit s);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      image_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    image_ch.valid          <= 1'b1;
    image_ch.image_byte     <= b;
    image_ch.start_of_image <= s;
    do @(posedge clk); while (!image_ch.ready);
    tracker.take_byte(b, s);
  endtask

  task automatic settle();
    image_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_type(input bit [7:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.expected_type = v;
  endtask

  function automatic void build_image(ref bit [7:0] img[$], input bit [7:0] typ,
                                      input bit [31:0] len, input int n);
    bit [15:0] crc;
    img = {8'h00, 8'h00, typ, len[31:24], len[23:16], len[15:8], len[7:0]};
    while (img.size() < HEADER_BYTES) img.push_back(8'($urandom));
    for (int i = 0; i < n; i++) img.push_back(8'($urandom));
    crc = CRC_INIT;
    for (int i = 2; i < img.size(); i++) crc = image_verdict_tracker::crc_step(crc, img[i]);
    img[0] = crc[15:8];
    img[1] = crc[7:0];
  endfunction

  task automatic send_image(input image_kind_e kind);
    bit [7:0]  img[$];
    bit [7:0]  typ;
    bit [31:0] len;
    int        n;
    int        r;
    if (kind == IMG_NOISE) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      return;
    end
    typ = tracker.expected_type;
    if (kind == IMG_BAD_TYPE) typ = typ ^ 8'($urandom_range(1, 255));
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 70) len = $urandom_range(1, 20);
    else if (r < 95) len = $urandom_range(21, 64);
    else len = $urandom_range(65, 300);
    n = len;
    if (kind == IMG_HUGE) begin
      len = $urandom | 32'h0100_0000;
      n   = $urandom_range(5, 40);
    end
    build_image(img, typ, len, n);
    if (kind == IMG_BAD_CRC) img[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    if (kind == IMG_CUT) img = img[0:$urandom_range(0, img.size() - 2)];
    for (int i = 0; i < img.size(); i++) send_byte(img[i], i == 0);
    if (kind == IMG_TRAIL) repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_random_image();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) send_image(IMG_GOOD);
    else if (r < 62) send_image(IMG_BAD_CRC);
    else if (r < 72) send_image(IMG_BAD_TYPE);
    else if (r < 82) send_image(IMG_CUT);
    else if (r < 90) send_image(IMG_TRAIL);
    else if (r < 95) send_image(IMG_HUGE);
    else send_image(IMG_NOISE);
  endtask

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    bit [7:0] img[$];
    bit [7:0] phase_types[5];
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_data                <= 8'h00;
    image_ch.valid          <= 1'b0;
    image_ch.image_byte     <= 8'h00;
    image_ch.start_of_image <= 1'b0;
    quiet                    = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // drop bytes before any start, then cut a header short with a new start
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    build_image(img, 8'h00, 32'h0, 0);
    for (int i = 0; i < img.size(); i++) send_byte(img[i], i == 0);

    phase_types = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom), 8'h80};
    for (int p = 0; p < 5; p++) begin
      set_type(phase_types[p]);
      quiet = (p == 2);
      while (tracker.bytes_checked < (p + 1) * 220) send_random_image();
    end
    while (tracker.verdicts_due < 40) send_random_image();

    settle();
    repeat (10) @(posedge clk);
    if (tracker.pending.size() != 0)
      tracker.report($sformatf("%0d verdicts never arrived", tracker.pending.size()));
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/fihcv_pkg.sv
sv/fihcv_if.sv
sv/fihcv_front.sv
sv/fihcv_queue.sv
sv/fihcv_back.sv
sv/firmware_image_header_crc_verify_unit.sv
tb/sv/tb_top.sv
